/* rtl/dbcdr_pkg.sv */
// ----------------------------------------------------------------------------
// dbcdr_pkg
// Shared types and constants for the double-buffered cell diff renderer.
// ----------------------------------------------------------------------------
package dbcdr_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam logic [6:0] WIDTH_RESET  = 7'd64;
    localparam logic [6:0] HEIGHT_RESET = 7'd32;

    localparam logic [7:0]  SPACE_GLYPH = 8'h20;
    localparam logic [7:0]  BLACK_COLOR = 8'h00;
    localparam logic [15:0] RESET_CELL  = {BLACK_COLOR, SPACE_GLYPH};

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_CELL     = 2'd1,
        KIND_NOCHANGE = 2'd2
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic clr_wr;
        logic draw_wr;
        logic fill_wr;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic cmp_adv;
        logic flush;
        logic ack;
        logic ack_status;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic draw_oob;
        logic render_oob;
        logic last_clear;
        logic last_fill;
        logic last_col;
        logic cmp_vld;
        logic cmp_diff;
        logic pend_vld;
        logic out_free;
    } sts_t;

endpackage

/* rtl/dbcdr_ctrl.sv */
// ----------------------------------------------------------------------------
// dbcdr_ctrl
// Command sequencer: clearing pass, decode, fill sweep, row render walk and
// result hand-off.
// ----------------------------------------------------------------------------
module dbcdr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dbcdr_pkg::sts_t   sts,
    output dbcdr_pkg::ctl_t   ctl
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_FILL   = 7'b0001000,
        S_RENDER = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_ACK    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   ack_st_reg, ack_st_next;
    logic   adv;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = done_reg;
        ack_st_next = ack_st_reg;
        ctl         = '0;
        in_stall    = 1'b1;
        // compare stage retires unless it needs the output slot and that is busy
        adv = sts.cmp_vld && (!sts.cmp_diff || !sts.pend_vld || sts.out_free);

        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.last_clear)
                begin
                    ctl.idx_clr = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.idx_clr = 1'b1;
                done_next   = 1'b0;
                case (sts.cmd)
                    dbcdr_pkg::CMD_DRAW:
                    begin
                        ack_st_next = sts.draw_oob;
                        ctl.draw_wr = !sts.draw_oob;
                        state_next  = S_ACK;
                    end
                    dbcdr_pkg::CMD_FILL:
                    begin
                        state_next = S_FILL;
                    end
                    dbcdr_pkg::CMD_RENDER:
                    begin
                        if (sts.render_oob)
                        begin
                            ack_st_next = 1'b1;
                            state_next  = S_ACK;
                        end
                        else
                        begin
                            state_next = S_RENDER;
                        end
                    end
                    default:
                    begin
                        ack_st_next = 1'b0;
                        state_next  = S_ACK;
                    end
                endcase
            end
            S_FILL:
            begin
                ctl.fill_wr = 1'b1;
                ctl.idx_inc = 1'b1;
                if (sts.last_fill)
                begin
                    ack_st_next = 1'b0;
                    state_next  = S_ACK;
                end
            end
            S_RENDER:
            begin
                ctl.cmp_adv = adv;
                if (!done_reg && (!sts.cmp_vld || adv))
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.idx_inc = 1'b1;
                    if (sts.last_col)
                    begin
                        done_next = 1'b1;
                    end
                end
                if (done_reg && !sts.cmp_vld)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ACK:
            begin
                if (sts.out_free)
                begin
                    ctl.ack        = 1'b1;
                    ctl.ack_status = ack_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            done_reg   <= 1'b0;
            ack_st_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            ack_st_reg <= ack_st_next;
        end
    end

endmodule

/* rtl/dbcdr_dpath.sv */
// ----------------------------------------------------------------------------
// dbcdr_dpath
// Cell memories (one per buffer), address arithmetic, compare stage, pending
// changed-cell register and output register.
// ----------------------------------------------------------------------------
module dbcdr_dpath #(
    parameter int MAX_WIDTH  = dbcdr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dbcdr_pkg::MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_enable,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic [1:0]        command,
    input  logic [7:0]        row,
    input  logic [7:0]        column,
    input  logic [7:0]        glyph,
    input  logic [7:0]        color,
    input  dbcdr_pkg::ctl_t   ctl,
    output dbcdr_pkg::sts_t   sts,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic              status,
    output logic [5:0]        out_row,
    output logic [5:0]        out_column,
    output logic [7:0]        out_glyph,
    output logic [7:0]        out_color,
    output logic              last
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW    = 15;

    logic [6:0]    wid_reg, hgt_reg;
    logic [6:0]    w_eff, h_eff;
    logic          act_reg;

    dbcdr_pkg::cmd_t cmd_reg;
    logic [7:0]    row_reg, col_reg, glyph_reg, color_reg;

    logic [AW-1:0] idx_reg;
    logic [XW-1:0] idx_ext, row_base, fill_total_m1;
    logic [AW-1:0] draw_addr, rd_addr;

    logic          cmp_vld_reg;
    logic [5:0]    cmp_col_reg;
    logic [AW-1:0] cmp_addr_reg;
    logic [15:0]   rd0_reg, rd1_reg, act_rd, oth_rd;
    logic          cmp_diff;

    logic          pend_vld_reg;
    logic [5:0]    pend_col_reg;
    logic [7:0]    pend_glyph_reg, pend_color_reg;

    logic          out_valid_reg, out_free, load;
    logic [1:0]    kind_reg, kind_next;
    logic          status_reg, status_next;
    logic [5:0]    orow_reg, orow_next, ocol_reg, ocol_next;
    logic [7:0]    oglyph_reg, oglyph_next, ocolor_reg, ocolor_next;
    logic          last_reg, last_next;
    logic          bottom;

    logic          we0, we1;
    logic [AW-1:0] wa0, wa1;
    logic [15:0]   wd0, wd1;
    logic [15:0]   mem0 [CELLS];
    logic [15:0]   mem1 [CELLS];

    // clamp configured dimensions to 1..max
    always_comb
    begin
        if (wid_reg == 7'd0)
            w_eff = 7'd1;
        else if (wid_reg > 7'(MAX_WIDTH))
            w_eff = 7'(MAX_WIDTH);
        else
            w_eff = wid_reg;

        if (hgt_reg == 7'd0)
            h_eff = 7'd1;
        else if ({1'b0, hgt_reg} > 8'(MAX_HEIGHT))
            h_eff = 7'(MAX_HEIGHT);
        else
            h_eff = hgt_reg;
    end

    assign idx_ext       = XW'(idx_reg);
    assign row_base      = XW'(row_reg) * XW'(w_eff);
    assign draw_addr     = AW'(row_base + XW'(col_reg));
    assign rd_addr       = AW'(row_base + idx_ext);
    assign fill_total_m1 = XW'(h_eff) * XW'(w_eff) - XW'(1);
    assign bottom        = (row_reg == {1'b0, h_eff - 7'd1});

    assign act_rd   = act_reg ? rd1_reg : rd0_reg;
    assign oth_rd   = act_reg ? rd0_reg : rd1_reg;
    assign cmp_diff = (act_rd != oth_rd);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.draw_oob   = (row_reg >= {1'b0, h_eff}) || (col_reg >= {1'b0, w_eff});
        sts.render_oob = (row_reg >= {1'b0, h_eff});
        sts.last_clear = (idx_ext == XW'(CELLS - 1));
        sts.last_fill  = (idx_ext == fill_total_m1);
        sts.last_col   = (idx_ext == XW'(w_eff) - XW'(1));
        sts.cmp_vld    = cmp_vld_reg;
        sts.cmp_diff   = cmp_diff;
        sts.pend_vld   = pend_vld_reg;
        sts.out_free   = out_free;
    end

    // memory write steering; the render write-back goes to the other buffer
    always_comb
    begin
        we0 = 1'b0;
        we1 = 1'b0;
        wa0 = idx_reg;
        wa1 = idx_reg;
        wd0 = dbcdr_pkg::RESET_CELL;
        wd1 = dbcdr_pkg::RESET_CELL;
        if (ctl.clr_wr)
        begin
            we0 = 1'b1;
            we1 = 1'b1;
        end
        else if (ctl.draw_wr || ctl.fill_wr)
        begin
            wa0 = ctl.draw_wr ? draw_addr : idx_reg;
            wa1 = wa0;
            wd0 = {color_reg, glyph_reg};
            wd1 = wd0;
            we0 = !act_reg;
            we1 = act_reg;
        end
        else if (ctl.cmp_adv)
        begin
            wa0 = cmp_addr_reg;
            wa1 = cmp_addr_reg;
            wd0 = {oth_rd[15:8], dbcdr_pkg::SPACE_GLYPH};
            wd1 = wd0;
            we0 = act_reg;
            we1 = !act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we0)
            mem0[wa0] <= wd0;
        if (ctl.rd_en)
            rd0_reg <= mem0[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
            mem1[wa1] <= wd1;
        if (ctl.rd_en)
            rd1_reg <= mem1[rd_addr];
    end

    // output register load: ack, end-of-row flush, or push of the held cell
    always_comb
    begin
        load        = 1'b0;
        kind_next   = dbcdr_pkg::KIND_ACK;
        status_next = 1'b0;
        orow_next   = 6'd0;
        ocol_next   = 6'd0;
        oglyph_next = 8'd0;
        ocolor_next = 8'd0;
        last_next   = 1'b1;
        if (ctl.ack)
        begin
            load        = 1'b1;
            status_next = ctl.ack_status;
        end
        else if (ctl.flush)
        begin
            load = 1'b1;
            if (pend_vld_reg)
            begin
                kind_next   = dbcdr_pkg::KIND_CELL;
                orow_next   = row_reg[5:0];
                ocol_next   = pend_col_reg;
                oglyph_next = pend_glyph_reg;
                ocolor_next = pend_color_reg;
            end
            else
            begin
                kind_next = dbcdr_pkg::KIND_NOCHANGE;
            end
        end
        else if (ctl.cmp_adv && cmp_diff && pend_vld_reg)
        begin
            load        = 1'b1;
            kind_next   = dbcdr_pkg::KIND_CELL;
            orow_next   = row_reg[5:0];
            ocol_next   = pend_col_reg;
            oglyph_next = pend_glyph_reg;
            ocolor_next = pend_color_reg;
            last_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_reg       <= dbcdr_pkg::WIDTH_RESET;
            hgt_reg       <= dbcdr_pkg::HEIGHT_RESET;
            act_reg       <= 1'b0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    dbcdr_pkg::REG_WIDTH:  wid_reg <= cfg_data;
                    dbcdr_pkg::REG_HEIGHT: hgt_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (ctl.flush && bottom)
                act_reg <= !act_reg;

            if (ctl.idx_clr)
                idx_reg <= '0;
            else if (ctl.idx_inc)
                idx_reg <= idx_reg + AW'(1);

            if (ctl.rd_en)
                cmp_vld_reg <= 1'b1;
            else if (ctl.cmp_adv)
                cmp_vld_reg <= 1'b0;

            if (ctl.flush)
                pend_vld_reg <= 1'b0;
            else if (ctl.cmp_adv && cmp_diff)
                pend_vld_reg <= 1'b1;

            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg   <= dbcdr_pkg::cmd_t'(command);
            row_reg   <= row;
            col_reg   <= column;
            glyph_reg <= glyph;
            color_reg <= color;
        end
        if (ctl.rd_en)
        begin
            cmp_col_reg  <= idx_ext[5:0];
            cmp_addr_reg <= rd_addr;
        end
        // a differing cell is held until the next one, or the row end, sets its last flag
        if (ctl.cmp_adv && cmp_diff)
        begin
            pend_col_reg   <= cmp_col_reg;
            pend_glyph_reg <= act_rd[7:0];
            pend_color_reg <= act_rd[15:8];
        end
        if (load)
        begin
            kind_reg   <= kind_next;
            status_reg <= status_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            oglyph_reg <= oglyph_next;
            ocolor_reg <= ocolor_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign status     = status_reg;
    assign out_row    = orow_reg;
    assign out_column = ocol_reg;
    assign out_glyph  = oglyph_reg;
    assign out_color  = ocolor_reg;
    assign last       = last_reg;

endmodule

/* rtl/double_buffered_cell_diff_renderer_unit.sv */
// ----------------------------------------------------------------------------
// double_buffered_cell_diff_renderer_unit
// Draw/no-op: latched, decoded, then acknowledged. Fill: writes all width*height
// cells, then acknowledges. Render row: one cell per cycle through the read port of
// each buffer memory, held while a changed cell waits for a busy output slot.
// One item at a time: the next is taken the cycle after its last result loads.
// Reset: both buffers cleared one cell a cycle, all MAX_WIDTH*MAX_HEIGHT cells.
// ----------------------------------------------------------------------------
module double_buffered_cell_diff_renderer_unit #(
    parameter int MAX_WIDTH  = dbcdr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dbcdr_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    input  logic [7:0]  glyph,
    input  logic [7:0]  color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic        status,
    output logic [5:0]  out_row,
    output logic [5:0]  out_column,
    output logic [7:0]  out_glyph,
    output logic [7:0]  out_color,
    output logic        last
);

    dbcdr_pkg::ctl_t ctl;
    dbcdr_pkg::sts_t sts;

    dbcdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    dbcdr_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .row              (row),
        .column           (column),
        .glyph            (glyph),
        .color            (color),
        .ctl              (ctl),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .status           (status),
        .out_row          (out_row),
        .out_column       (out_column),
        .out_glyph        (out_glyph),
        .out_color        (out_color),
        .last             (last)
    );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: double_buffered_cell_diff_renderer_unit
// Self-checking bench. A directed list covers the reset state, bounds errors,
// no-op, fill and full-width renders. It is followed by random draw/fill/render
// frames over several screen sizes. Results are checked against a behavioural
// screen model of both buffers and the active select, or a typed row's ack.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS        = dbcdr_pkg::MAX_WIDTH_DEF * dbcdr_pkg::MAX_HEIGHT_DEF;
    localparam int RANDOM_ITEMS = 209;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_DIR      = 21;
    localparam int NUM_SIZES    = 7;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_enable;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [7:0]  glyph;
    logic [7:0]  color;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic        status;
    logic [5:0]  out_row;
    logic [5:0]  out_column;
    logic [7:0]  out_glyph;
    logic [7:0]  out_color;
    logic        last;

    typedef struct {
        dbcdr_pkg::kind_t kind;
        logic             status;
        logic [5:0]       rrow;
        logic [5:0]       rcol;
        logic [7:0]       rglyph;
        logic [7:0]       rcolor;
        logic             rlast;
    } report_t;

    // one command item; typed rows carry their single acknowledge by hand
    typedef struct packed {
        dbcdr_pkg::cmd_t  cmd;
        logic [7:0]       r;
        logic [7:0]       c;
        logic [7:0]       g;
        logic [7:0]       k;
        logic             typed;
        dbcdr_pkg::kind_t tkind;
        logic             tstatus;
    } step_row_t;

    // directed list, starting from the reset size of 64 x 32
    step_row_t dir_tbl [NUM_DIR] = '{
        '{dbcdr_pkg::CMD_RENDER, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, dbcdr_pkg::KIND_NOCHANGE, 1'b0},
        '{dbcdr_pkg::CMD_DRAW, 8'd31, 8'd63, 8'hFF, 8'hFF, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_DRAW, 8'd32, 8'd0, 8'h11, 8'h22, 1'b1, dbcdr_pkg::KIND_ACK, 1'b1},
        '{dbcdr_pkg::CMD_DRAW, 8'd0, 8'd64, 8'h33, 8'h44, 1'b1, dbcdr_pkg::KIND_ACK, 1'b1},
        '{dbcdr_pkg::CMD_DRAW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, dbcdr_pkg::KIND_ACK, 1'b1},
        '{dbcdr_pkg::CMD_DRAW, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_RENDER, 8'd32, 8'd0, 8'h00, 8'h00, 1'b1, dbcdr_pkg::KIND_ACK, 1'b1},
        '{dbcdr_pkg::CMD_RENDER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, dbcdr_pkg::KIND_ACK, 1'b1},
        '{dbcdr_pkg::CMD_RENDER, 8'd0, 8'd0, 8'h00, 8'h00, 1'b0, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_RENDER, 8'd31, 8'd0, 8'h00, 8'h00, 1'b0, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_RENDER, 8'd31, 8'd0, 8'h00, 8'h00, 1'b0, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_FILL, 8'd0, 8'd0, 8'hAA, 8'h55, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_RENDER, 8'd5, 8'd0, 8'h00, 8'h00, 1'b0, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_RENDER, 8'd5, 8'd0, 8'h00, 8'h00, 1'b0, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_DRAW, 8'd0, 8'd0, 8'h20, 8'h00, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_FILL, 8'd0, 8'd0, 8'h20, 8'h00, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_RENDER, 8'd0, 8'd0, 8'h00, 8'h00, 1'b0, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_RENDER, 8'd31, 8'd0, 8'h00, 8'h00, 1'b0, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_DRAW, 8'd10, 8'd10, 8'h7F, 8'h80, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0},
        '{dbcdr_pkg::CMD_NOP, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1, dbcdr_pkg::KIND_ACK, 1'b0}
    };

    // screen sizes walked by the random part, register values as written
    logic [6:0] size_w [NUM_SIZES] = '{7'd4, 7'd0, 7'd127, 7'd1, 7'd33, 7'd64, 7'd7};
    logic [6:0] size_h [NUM_SIZES] = '{7'd3, 7'd0, 7'd5, 7'd127, 7'd17, 7'd64, 7'd1};

    report_t     reports_q [$];
    logic [15:0] screen_mem [0:2*CELLS-1];
    logic        front_buf;
    logic [6:0]  scr_w;
    logic [6:0]  scr_h;
    int          fail_cnt  = 0;
    int          items_sent = 0;
    bit          quiet     = 1'b0;
    bit          hold_req  = 1'b0;

    double_buffered_cell_diff_renderer_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .row              (row),
        .column           (column),
        .glyph            (glyph),
        .color            (color),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .status           (status),
        .out_row          (out_row),
        .out_column       (out_column),
        .out_glyph        (out_glyph),
        .out_color        (out_color),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("double_buffered_cell_diff_renderer_unit test failed");
        $finish;
    end

    function automatic int eff_dim(logic [6:0] v, int maxv);
        if (v == 7'd0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    // screen model: applies one command and returns the result items it causes
    function automatic void screen_cmd_effect(input step_row_t s, ref report_t reps [$]);
        int          w;
        int          h;
        int          base_a;
        int          base_b;
        int          idx;
        logic [15:0] a;
        logic [15:0] b;
        report_t     rep;

        w      = eff_dim(scr_w, dbcdr_pkg::MAX_WIDTH_DEF);
        h      = eff_dim(scr_h, dbcdr_pkg::MAX_HEIGHT_DEF);
        base_a = front_buf ? CELLS : 0;
        base_b = front_buf ? 0 : CELLS;
        rep    = '{dbcdr_pkg::KIND_ACK, 1'b0, 6'd0, 6'd0, 8'd0, 8'd0, 1'b1};
        reps.delete();
        case (s.cmd)
            dbcdr_pkg::CMD_DRAW:
            begin
                if (int'(s.r) >= h || int'(s.c) >= w)
                    rep.status = 1'b1;
                else
                    screen_mem[base_a + int'(s.r) * w + int'(s.c)] = {s.k, s.g};
                reps.push_back(rep);
            end
            dbcdr_pkg::CMD_FILL:
            begin
                for (int i = 0; i < w * h; i++)
                    screen_mem[base_a + i] = {s.k, s.g};
                reps.push_back(rep);
            end
            dbcdr_pkg::CMD_RENDER:
            begin
                if (int'(s.r) >= h)
                begin
                    rep.status = 1'b1;
                    reps.push_back(rep);
                end
                else
                begin
                    for (int i = 0; i < w; i++)
                    begin
                        idx = int'(s.r) * w + i;
                        a   = screen_mem[base_a + idx];
                        b   = screen_mem[base_b + idx];
                        if (a != b)
                            reps.push_back('{dbcdr_pkg::KIND_CELL, 1'b0, s.r[5:0], 6'(i),
                                             a[7:0], a[15:8], 1'b0});
                        // back buffer keeps its colour, glyph goes blank
                        screen_mem[base_b + idx] = {b[15:8], dbcdr_pkg::SPACE_GLYPH};
                    end
                    if (int'(s.r) == h - 1)
                        front_buf = ~front_buf;
                    if (reps.size() == 0)
                    begin
                        rep.kind = dbcdr_pkg::KIND_NOCHANGE;
                        reps.push_back(rep);
                    end
                    else
                        reps[reps.size()-1].rlast = 1'b1;
                end
            end
            default:
                reps.push_back(rep);
        endcase
    endfunction

    function automatic step_row_t mk(dbcdr_pkg::cmd_t cmd, int r, int c, int g, int k);
        return '{cmd, 8'(r), 8'(c), 8'(g), 8'(k), 1'b0, dbcdr_pkg::KIND_ACK, 1'b0};
    endfunction

    // called at a rising edge; returns at the edge the item is taken
    task automatic offer(input step_row_t s);
        report_t reps [$];

        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= s.cmd;
        row      <= s.r;
        column   <= s.c;
        glyph    <= s.g;
        color    <= s.k;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        screen_cmd_effect(s, reps);
        if (s.typed)
            reports_q.push_back('{s.tkind, s.tstatus, 6'd0, 6'd0, 8'd0, 8'd0, 1'b1});
        else
            foreach (reps[i])
                reports_q.push_back(reps[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (reports_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [6:0] w, input logic [6:0] h);
        cfg_write_enable <= 1'b1;
        cfg_index        <= dbcdr_pkg::REG_WIDTH;
        cfg_data         <= w;
        @(posedge clk);
        scr_w = w;
        cfg_index <= dbcdr_pkg::REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        scr_h = h;
        cfg_write_enable <= 1'b0;
    endtask

    // perhaps a fill, then draws and some noise, then renders rows, mostly ending on the last
    task automatic run_frame(input bit force_fill);
        int w;
        int h;
        int nd;

        w = eff_dim(scr_w, dbcdr_pkg::MAX_WIDTH_DEF);
        h = eff_dim(scr_h, dbcdr_pkg::MAX_HEIGHT_DEF);
        if (force_fill || (w * h <= 256 && $urandom_range(0, 3) == 0))
            offer(mk(dbcdr_pkg::CMD_FILL, $urandom, $urandom, $urandom, $urandom));
        nd = $urandom_range(1, 6);
        for (int i = 0; i < nd; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                offer(mk(dbcdr_pkg::CMD_DRAW, $urandom_range(0, h - 1),
                         $urandom_range(0, w - 1), $urandom, $urandom));
            else
                offer(mk(dbcdr_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom));
        end
        case ($urandom_range(0, 4))
            0: offer(mk(dbcdr_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom));
            1: offer(mk(dbcdr_pkg::CMD_RENDER, $urandom_range(h, 255), $urandom, $urandom,
                        $urandom));
            default: ;
        endcase
        if (h <= 8)
        begin
            for (int i = 0; i < h - 1; i++)
                offer(mk(dbcdr_pkg::CMD_RENDER, i, $urandom, $urandom, $urandom));
        end
        else
        begin
            repeat (3)
                offer(mk(dbcdr_pkg::CMD_RENDER, $urandom_range(0, h - 2), $urandom, $urandom,
                         $urandom));
        end
        // now and then the frame is left without its swapping row
        if ($urandom_range(0, 5) != 0)
            offer(mk(dbcdr_pkg::CMD_RENDER, h - 1, $urandom, $urandom, $urandom));
    endtask

    function automatic void chk(string fname, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        report_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_q.size() == 0)
            begin
                $error("result item with none outstanding: kind %0d", kind);
                fail_cnt++;
            end
            else
            begin
                want = reports_q.pop_front();
                chk("kind",       int'(want.kind),   int'(kind));
                chk("status",     int'(want.status), int'(status));
                chk("out_row",    int'(want.rrow),   int'(out_row));
                chk("out_column", int'(want.rcol),   int'(out_column));
                chk("out_glyph",  int'(want.rglyph), int'(out_glyph));
                chk("out_color",  int'(want.rcolor), int'(out_color));
                chk("last",       int'(want.rlast),  int'(last));
            end
        end
    end

    // receiver: random stalls, or a counted hold-off on request
    initial
    begin : receiver
        int hold_left;

        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    initial
    begin : sender
        int  p;
        int  start;
        bit  forced;

        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = dbcdr_pkg::REG_WIDTH;
        cfg_data         = 7'd0;
        in_valid         = 1'b0;
        command          = dbcdr_pkg::CMD_NOP;
        row              = 8'd0;
        column           = 8'd0;
        glyph            = 8'd0;
        color            = 8'd0;
        for (int i = 0; i < 2 * CELLS; i++)
            screen_mem[i] = dbcdr_pkg::RESET_CELL;
        front_buf = 1'b0;
        scr_w     = dbcdr_pkg::WIDTH_RESET;
        scr_h     = dbcdr_pkg::HEIGHT_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
            offer(dir_tbl[i]);

        p = 0;
        while (items_sent < NUM_DIR + RANDOM_ITEMS)
        begin
            drain();
            write_size(size_w[p % NUM_SIZES], size_h[p % NUM_SIZES]);
            quiet = (p % NUM_SIZES == 4);
            // wide rows behind a held-off receiver back the block up
            if (p % NUM_SIZES == 2)
                hold_req = 1'b1;
            forced = (p % NUM_SIZES == 5);
            start  = items_sent;
            while (items_sent - start < 32 && items_sent < NUM_DIR + RANDOM_ITEMS)
            begin
                run_frame(forced);
                forced = 1'b0;
            end
            p++;
        end
        quiet = 1'b0;

        drain();
        repeat (100) @(posedge clk);
        if (fail_cnt == 0)
            $display("double_buffered_cell_diff_renderer_unit test passed");
        else
            $display("double_buffered_cell_diff_renderer_unit test failed");
        $finish;
    end

endmodule

/* double_buffered_cell_diff_renderer_unit.f */
rtl/dbcdr_pkg.sv
rtl/dbcdr_ctrl.sv
rtl/dbcdr_dpath.sv
rtl/double_buffered_cell_diff_renderer_unit.sv
verif/tb.sv
